@@ sv/mlpq_pkg.sv @@
// ----------------------------------------------------------------------------
// mlpq_pkg
// Shared types and codes for the multi-level priority queue.
// ----------------------------------------------------------------------------
package mlpq_pkg;

    typedef logic signed [31:0] value_t;

    typedef enum logic [2:0] {
        ST_ENQ    = 3'd0,
        ST_DEQ    = 3'd1,
        ST_BADPRI = 3'd2,
        ST_EMPTY  = 3'd3,
        ST_FULL   = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_READ
    } state_t;

    typedef enum logic {
        KIND_ENQ = 1'b0,
        KIND_DEQ = 1'b1
    } kind_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;      // latch the incoming item
        logic execute;      // perform the operation, load result fields
        logic deliver_mem;  // load value from RAM read data, raise valid
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic slot_free;    // output register free or being emptied
        logic needs_read;   // dequeue that hits a stored value
    } stat_t;

endpackage

@@ sv/mlpq_if.sv @@
// ----------------------------------------------------------------------------
// mlpq_req_if / mlpq_rsp_if
// Valid/ready channels carrying request and response items.
// ----------------------------------------------------------------------------
interface mlpq_req_if;
    logic                valid;
    logic                ready;
    logic                kind;
    mlpq_pkg::value_t    value;
    logic [2:0]          priority_req;

    modport source (output valid, kind, value, priority_req, input ready);
    modport sink   (input valid, kind, value, priority_req, output ready);
endinterface

interface mlpq_rsp_if;
    logic                valid;
    logic                ready;
    mlpq_pkg::value_t    result_value;
    logic [2:0]          status;
    logic                all_empty;

    modport source (output valid, result_value, status, all_empty, input ready);
    modport sink   (input valid, result_value, status, all_empty, output ready);
endinterface

@@ sv/mlpq_ram.sv @@
// ----------------------------------------------------------------------------
// mlpq_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mlpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 80
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/mlpq_ctrl.sv @@
// ----------------------------------------------------------------------------
// mlpq_ctrl
// Sequencer: capture item, execute, optional RAM read-out cycle.
// ----------------------------------------------------------------------------
module mlpq_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  mlpq_pkg::stat_t stat,
    output mlpq_pkg::cmd_t  cmd
);
    import mlpq_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (stat.slot_free)
                begin
                    state_next = stat.needs_read ? S_READ : S_IDLE;
                end
            end
            S_READ:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_ready       = 1'b0;
        cmd.capture     = 1'b0;
        cmd.execute     = 1'b0;
        cmd.deliver_mem = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready   = 1'b1;
                cmd.capture = req_valid;
            end
            S_EXEC:
            begin
                cmd.execute = stat.slot_free;
            end
            S_READ:
            begin
                cmd.deliver_mem = 1'b1;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

endmodule

@@ sv/mlpq_dp.sv @@
// ----------------------------------------------------------------------------
// mlpq_dp
// Level pointers/counts, entry RAM, priority encoder and result register.
// ----------------------------------------------------------------------------
module mlpq_dp #(
    parameter int LEVELS      = 5,
    parameter int LEVEL_DEPTH = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  mlpq_pkg::cmd_t    cmd,
    output mlpq_pkg::stat_t   stat,
    input  logic              req_kind,
    input  mlpq_pkg::value_t  req_value,
    input  logic [2:0]        req_priority,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output mlpq_pkg::value_t  rsp_result_value,
    output logic [2:0]        rsp_status,
    output logic              rsp_all_empty
);
    import mlpq_pkg::*;

    localparam int LVL_W    = $clog2(LEVELS);
    localparam int PTR_W    = $clog2(LEVEL_DEPTH);
    localparam int CNT_W    = $clog2(LEVEL_DEPTH + 1);
    localparam int RAM_AW   = LVL_W + PTR_W;
    localparam int RAM_D    = LEVELS << PTR_W;

    // captured item
    logic             kind_reg;
    value_t           value_reg;
    logic [2:0]       pri_reg;

    // per-level state
    logic [PTR_W-1:0] head_reg  [LEVELS];
    logic [PTR_W-1:0] head_next [LEVELS];
    logic [PTR_W-1:0] tail_reg  [LEVELS];
    logic [PTR_W-1:0] tail_next [LEVELS];
    logic [CNT_W-1:0] count_reg [LEVELS];
    logic [CNT_W-1:0] count_next[LEVELS];

    // result register
    logic             out_valid_reg;
    logic             out_valid_next;
    value_t           out_value_reg;
    value_t           out_value_next;
    status_t          out_status_reg;
    status_t          out_status_next;
    logic             out_empty_reg;
    logic             out_empty_next;

    logic [LEVELS-1:0] nonempty;
    logic [LEVELS-1:0] full;
    logic [LEVELS-1:0] over;
    logic [LEVELS-1:0] nonempty_after;
    logic              pri_ok;
    logic [LVL_W-1:0]  enq_lvl;
    logic [LVL_W-1:0]  deq_lvl;
    logic              deq_any;
    logic              is_deq;
    logic              enq_ok;
    logic              deq_hit;
    logic [PTR_W-1:0]  wr_ptr;
    logic [PTR_W-1:0]  rd_ptr;
    logic [31:0]       ram_rdata;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(LEVEL_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg  <= req_kind;
            value_reg <= req_value;
            pri_reg   <= req_priority;
        end
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
        out_empty_reg  <= out_empty_next;
    end

    // level flags and dequeue select
    always_comb
    begin
        for (int i = 0; i < LEVELS; i++)
        begin
            nonempty[i] = (count_reg[i] != '0);
            full[i]     = (count_reg[i] == CNT_W'(LEVEL_DEPTH));
            over[i]     = (count_reg[i] > CNT_W'(LEVEL_DEPTH));
        end
        deq_lvl = '0;
        for (int i = LEVELS - 1; i >= 0; i--)
        begin
            if (nonempty[i])
            begin
                deq_lvl = LVL_W'(i);
            end
        end
    end

    assign deq_any = |nonempty;
    assign is_deq  = (kind_reg == KIND_DEQ);
    assign pri_ok  = ({1'b0, pri_reg} < 4'(LEVELS));
    assign enq_lvl = pri_reg[LVL_W-1:0];
    assign enq_ok  = !is_deq && pri_ok && !full[enq_lvl];
    assign deq_hit = is_deq && deq_any;
    assign wr_ptr  = tail_reg[enq_lvl];
    assign rd_ptr  = head_reg[deq_lvl];

    assign stat.slot_free  = !out_valid_reg || rsp_ready;
    assign stat.needs_read = deq_hit;

    // pointer and count update
    always_comb
    begin
        for (int i = 0; i < LEVELS; i++)
        begin
            head_next[i]  = head_reg[i];
            tail_next[i]  = tail_reg[i];
            count_next[i] = count_reg[i];
            if (cmd.execute && enq_ok && (enq_lvl == LVL_W'(i)))
            begin
                tail_next[i]  = ptr_inc(tail_reg[i]);
                count_next[i] = count_reg[i] + CNT_W'(1);
            end
            if (cmd.execute && deq_hit && (deq_lvl == LVL_W'(i)))
            begin
                head_next[i]  = ptr_inc(head_reg[i]);
                count_next[i] = count_reg[i] - CNT_W'(1);
            end
            nonempty_after[i] = (count_next[i] != '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LEVELS; i++)
            begin
                head_reg[i]  <= '0;
                tail_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
            out_valid_reg <= 1'b0;
        end
        else
        begin
            for (int i = 0; i < LEVELS; i++)
            begin
                head_reg[i]  <= head_next[i];
                tail_reg[i]  <= tail_next[i];
                count_reg[i] <= count_next[i];
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // result register load
    always_comb
    begin
        out_valid_next  = out_valid_reg && !rsp_ready;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        out_empty_next  = out_empty_reg;
        if (cmd.execute)
        begin
            out_valid_next = !deq_hit;
            out_empty_next = ~|nonempty_after;
            out_value_next = '0;
            if (is_deq)
            begin
                if (deq_any)
                begin
                    out_status_next = ST_DEQ;
                end
                else
                begin
                    out_status_next = ST_EMPTY;
                    out_value_next  = '1;
                end
            end
            else if (!pri_ok)
            begin
                out_status_next = ST_BADPRI;
            end
            else if (full[enq_lvl])
            begin
                out_status_next = ST_FULL;
            end
            else
            begin
                out_status_next = ST_ENQ;
            end
        end
        else if (cmd.deliver_mem)
        begin
            out_valid_next = 1'b1;
            out_value_next = value_t'(ram_rdata);
        end
    end

    mlpq_ram #(
        .WIDTH (32),
        .DEPTH (RAM_D)
    ) u_store (
        .clk   (clk),
        .we    (cmd.execute && enq_ok),
        .waddr (RAM_AW'({enq_lvl, wr_ptr})),
        .wdata (value_reg),
        .re    (cmd.execute && deq_hit),
        .raddr (RAM_AW'({deq_lvl, rd_ptr})),
        .rdata (ram_rdata)
    );

    assign rsp_valid        = out_valid_reg;
    assign rsp_result_value = out_value_reg;
    assign rsp_status       = out_status_reg;
    assign rsp_all_empty    = out_empty_reg;

    // no level ever holds more than its depth
    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        over == '0)
        else $error("level count beyond depth");

    // read-out cycle only ever lands in an empty result slot
    a_read_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.deliver_mem |-> !out_valid_reg)
        else $error("RAM read-out overwrote a pending result");

    // a read-out always follows a dequeue that hit data
    a_read_follows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.execute && deq_hit |=> cmd.deliver_mem)
        else $error("dequeue read not delivered");

    // a successful enqueue leaves the queue non-empty
    a_enq_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_status_reg == ST_ENQ) |-> !out_empty_reg)
        else $error("enqueue reported all levels empty");

    // empty dequeue returns all ones with the empty flag
    a_empty_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_status_reg == ST_EMPTY)
            |-> out_empty_reg && (out_value_reg == '1))
        else $error("empty dequeue result malformed");

endmodule

@@ sv/multi_level_priority_queue_core.sv @@
// An item's result is loaded as its execute state completes; for a dequeue that
//   returns a stored value, the value comes from the RAM in the read-out state.
// Items are taken one at a time: a new item is accepted only once the controller
//   sequence capture -> execute -> RAM read-out is back in idle.
// Reset (rst_n, async, active low) clears all level pointers and counts at once;
//   the entry RAM is not cleared and needs no sweep.
// ----------------------------------------------------------------------------
// multi_level_priority_queue_core
// Strict-priority queue with LEVELS FIFO levels, level 0 served first.
// ----------------------------------------------------------------------------
//
// Structure:
//   mlpq_ctrl - three-state sequencer (idle / execute / read-out).
//   mlpq_dp   - per-level head, tail and count registers, priority encoder
//               over the non-empty flags, one shared entry RAM addressed as
//               {level, pointer}, and the output result register.
//
// Item flow:
//   idle     : req is ready; an accepted item is latched.
//   execute  : waits until the result register is free (or being taken),
//              then updates pointers, writes the RAM on an enqueue, issues
//              the RAM read on a dequeue, and loads status / all_empty.
//   read-out : RAM data goes into the result value, result becomes valid.
// A new item is accepted while the previous result still sits unclaimed in
// the output register.
//
// Refused items (bad priority, level full, empty dequeue) change no pointer, count or RAM.
module multi_level_priority_queue_core #(
    parameter int LEVELS      = 5,
    parameter int LEVEL_DEPTH = 16
) (
    input  logic  clk,
    input  logic  rst_n,
    mlpq_req_if.sink   req,
    mlpq_rsp_if.source rsp
);
    import mlpq_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    mlpq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    mlpq_dp #(
        .LEVELS      (LEVELS),
        .LEVEL_DEPTH (LEVEL_DEPTH)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .req_kind         (req.kind),
        .req_value        (req.value),
        .req_priority     (req.priority_req),
        .rsp_valid        (rsp.valid),
        .rsp_ready        (rsp.ready),
        .rsp_result_value (rsp.result_value),
        .rsp_status       (rsp.status),
        .rsp_all_empty    (rsp.all_empty)
    );

endmodule
